// ===== rtl/dlf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlf_pkg;

  // sizes of the layer
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_OUTPUTS = 16;
  localparam int ACC_WIDTH   = 48;

  // derived widths
  localparam int IN_AW   = $clog2(MAX_INPUTS);
  localparam int OUT_AW  = $clog2(MAX_OUTPUTS);
  localparam int W_AW    = IN_AW + OUT_AW;
  localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int CNT_W   = 7;
  localparam int NOUT_W  = 5;
  localparam int CFG_W   = 7;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;

  // input item selector
  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_ACT    = 2'd2
  } func_e;

  // configuration register index
  typedef enum logic [0:0] {
    REG_INPUTS  = 1'b0,
    REG_OUTPUTS = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MAC   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         neuron;
    logic signed [15:0] result;
    logic               saturated;
    logic               end_of_run;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } mac_sts_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               saturated;
  } mac_res_t;

endpackage

`default_nettype wire

// ===== rtl/dlf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/dlf_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dlf_pkg::mac_ctl_t             ctl_i,
  input  wire logic [dlf_pkg::DATA_W-1:0]    w_rdata_i,
  input  wire logic [dlf_pkg::DATA_W-1:0]    a_rdata_i,
  input  wire logic [dlf_pkg::DATA_W-1:0]    b_rdata_i,
  output dlf_pkg::mac_sts_t                  sts_o,
  output dlf_pkg::mac_res_t                  res_o
);

  localparam logic signed [dlf_pkg::ACC_WIDTH-1:0] RES_MAX = dlf_pkg::ACC_WIDTH'(32767);
  localparam logic signed [dlf_pkg::ACC_WIDTH-1:0] RES_MIN = -dlf_pkg::ACC_WIDTH'(32768);

  logic                                  rd_v_q;
  logic                                  prod_v_q;
  logic signed [dlf_pkg::PROD_W-1:0]     prod_q;
  logic signed [dlf_pkg::ACC_WIDTH-1:0]  acc_q;
  logic signed [dlf_pkg::ACC_WIDTH-1:0]  acc_d;
  logic signed [dlf_pkg::ACC_WIDTH-1:0]  bias_ext;
  logic signed [dlf_pkg::ACC_WIDTH-1:0]  sum;
  logic signed [dlf_pkg::ACC_WIDTH-1:0]  shifted;
  logic                                  over;
  logic                                  under;

  // valid flags follow the memory read and the multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q   <= ctl_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= $signed(w_rdata_i) * $signed(a_rdata_i);
    end
  end

  // accumulator, wraps at its width
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + dlf_pkg::ACC_WIDTH'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // bias add, floor shift to q8.8 and saturation
  always_comb begin
    bias_ext = dlf_pkg::ACC_WIDTH'($signed(b_rdata_i));
    sum      = acc_q + (bias_ext <<< 8);
    shifted  = sum >>> 8;
    over     = shifted > RES_MAX;
    under    = shifted < RES_MIN;
    res_o.saturated = over | under;
    if (over) begin
      res_o.result = 16'sh7fff;
    end else if (under) begin
      res_o.result = 16'sh8000;
    end else begin
      res_o.result = shifted[dlf_pkg::DATA_W-1:0];
    end
  end

  assign sts_o.busy = rd_v_q | prod_v_q;

endmodule

`default_nettype wire

// ===== rtl/dlf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlf_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire dlf_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output dlf_pkg::out_item_t                   out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_idx_i,
  input  wire logic [dlf_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic [dlf_pkg::DATA_W-1:0]           wdata_o,
  output logic                                 w_we_o,
  output logic [dlf_pkg::W_AW-1:0]             w_waddr_o,
  output logic                                 w_re_o,
  output logic [dlf_pkg::W_AW-1:0]             w_raddr_o,
  output logic                                 a_we_o,
  output logic [dlf_pkg::IN_AW-1:0]            a_waddr_o,
  output logic                                 a_re_o,
  output logic [dlf_pkg::IN_AW-1:0]            a_raddr_o,
  output logic                                 b_we_o,
  output logic [dlf_pkg::OUT_AW-1:0]           b_waddr_o,
  output logic                                 b_re_o,
  output logic [dlf_pkg::OUT_AW-1:0]           b_raddr_o,
  output dlf_pkg::mac_ctl_t                    mac_ctl_o,
  input  wire dlf_pkg::mac_sts_t               mac_sts_i,
  input  wire dlf_pkg::mac_res_t               mac_res_i
);

  localparam logic [dlf_pkg::CNT_W-1:0]  MAX_IN  = dlf_pkg::CNT_W'(dlf_pkg::MAX_INPUTS);
  localparam logic [dlf_pkg::NOUT_W-1:0] MAX_OUT = dlf_pkg::NOUT_W'(dlf_pkg::MAX_OUTPUTS);

  dlf_pkg::ctrl_state_e             state_q, state_d;
  logic [dlf_pkg::CFG_W-1:0]        inputs_q;
  logic [dlf_pkg::NOUT_W-1:0]       outputs_q;
  logic [dlf_pkg::CNT_W-1:0]        count_q, count_d;
  logic [dlf_pkg::CNT_W-1:0]        used_q, used_d;
  logic [dlf_pkg::NOUT_W-1:0]       nout_q, nout_d;
  logic [dlf_pkg::OUT_AW-1:0]       n_q, n_d;
  logic [dlf_pkg::CNT_W-1:0]        k_q, k_d;
  logic                             out_valid_q, out_valid_d;
  dlf_pkg::out_item_t               out_q, out_d;
  logic [dlf_pkg::CNT_W-1:0]        nin;
  logic [dlf_pkg::NOUT_W-1:0]       nout;
  logic [dlf_pkg::CNT_W-1:0]        cnt_new;
  logic                             accept;
  logic                             store_act;
  logic                             out_free;
  logic                             eor;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inputs_q  <= dlf_pkg::CFG_W'(dlf_pkg::MAX_INPUTS);
      outputs_q <= dlf_pkg::NOUT_W'(dlf_pkg::MAX_OUTPUTS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dlf_pkg::REG_INPUTS) begin
        inputs_q <= cfg_wdata_i;
      end else begin
        outputs_q <= cfg_wdata_i[dlf_pkg::NOUT_W-1:0];
      end
    end
  end

  // effective sizes, zero acts as one and large values clip
  always_comb begin
    if (inputs_q == '0) begin
      nin = dlf_pkg::CNT_W'(1);
    end else if (inputs_q > MAX_IN) begin
      nin = MAX_IN;
    end else begin
      nin = inputs_q;
    end
    if (outputs_q == '0) begin
      nout = dlf_pkg::NOUT_W'(1);
    end else if (outputs_q > MAX_OUT) begin
      nout = MAX_OUT;
    end else begin
      nout = outputs_q;
    end
  end

  assign in_stall_o = (state_q != dlf_pkg::ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign store_act  = (count_q < nin);
  assign cnt_new    = store_act ? count_q + dlf_pkg::CNT_W'(1) : count_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign eor        = ({1'b0, n_q} + dlf_pkg::NOUT_W'(1)) == nout_q;

  // memory addressing
  assign wdata_o   = in_data_i.value;
  assign w_waddr_o = {in_data_i.row[dlf_pkg::OUT_AW-1:0], in_data_i.col[dlf_pkg::IN_AW-1:0]};
  assign b_waddr_o = in_data_i.row[dlf_pkg::OUT_AW-1:0];
  assign a_waddr_o = count_q[dlf_pkg::IN_AW-1:0];
  assign w_raddr_o = {n_q, k_q[dlf_pkg::IN_AW-1:0]};
  assign a_raddr_o = k_q[dlf_pkg::IN_AW-1:0];
  assign b_raddr_o = n_q;

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    used_d      = used_q;
    nout_d      = nout_q;
    n_d         = n_q;
    k_d         = k_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    w_we_o      = 1'b0;
    a_we_o      = 1'b0;
    b_we_o      = 1'b0;
    w_re_o      = 1'b0;
    a_re_o      = 1'b0;
    b_re_o      = 1'b0;
    mac_ctl_o   = '0;

    unique case (state_q)
      dlf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.func)
            dlf_pkg::FUNC_WEIGHT: begin
              w_we_o = (32'(in_data_i.row) < dlf_pkg::MAX_OUTPUTS) &&
                       (32'(in_data_i.col) < dlf_pkg::MAX_INPUTS);
            end
            dlf_pkg::FUNC_BIAS: begin
              b_we_o = (32'(in_data_i.row) < dlf_pkg::MAX_OUTPUTS);
            end
            dlf_pkg::FUNC_ACT: begin
              a_we_o  = store_act;
              count_d = cnt_new;
              if (in_data_i.last) begin
                count_d = '0;
                used_d  = (cnt_new < nin) ? cnt_new : nin;
                nout_d  = nout;
                n_d     = '0;
                k_d     = '0;
                state_d = dlf_pkg::ST_MAC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dlf_pkg::ST_MAC: begin
        // one weight and one activation per cycle
        w_re_o          = 1'b1;
        a_re_o          = 1'b1;
        b_re_o          = (k_q == '0);
        mac_ctl_o.issue = 1'b1;
        mac_ctl_o.clear = (k_q == '0);
        k_d             = k_q + dlf_pkg::CNT_W'(1);
        if (k_d >= used_q) begin
          state_d = dlf_pkg::ST_DRAIN;
        end
      end
      dlf_pkg::ST_DRAIN: begin
        if (!mac_sts_i.busy) begin
          state_d = dlf_pkg::ST_EMIT;
        end
      end
      dlf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.neuron         = n_q;
          out_d.result         = mac_res_i.result;
          out_d.saturated      = mac_res_i.saturated;
          out_d.end_of_run     = eor;
          k_d                  = '0;
          if (eor) begin
            state_d = dlf_pkg::ST_IDLE;
          end else begin
            n_d     = n_q + dlf_pkg::OUT_AW'(1);
            state_d = dlf_pkg::ST_MAC;
          end
        end
      end
      default: begin
        state_d = dlf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlf_pkg::ST_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      nout_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      used_q      <= used_d;
      nout_q      <= nout_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // issue counter stays inside the used elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlf_pkg::ST_MAC) |-> (k_q < used_q))
    else $error("issue index beyond used elements");

  // no products still in flight when a neuron result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlf_pkg::ST_EMIT) |-> !mac_sts_i.busy)
    else $error("result taken with datapath busy");

  // element count is bounded and cleared while a sample is computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= MAX_IN) && ((state_q == dlf_pkg::ST_IDLE) || (count_q == '0)))
    else $error("element count out of range");

  // a new neuron result is produced only from the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == dlf_pkg::ST_EMIT))
    else $error("result appeared outside emit");
`endif

endmodule

`default_nettype wire

// ===== rtl/dense_layer_forward_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// weight, bias and activation transactions are accepted only while the controller is idle
// on the last activation, each neuron issues one weight ram read per element, then drains the
// read, multiply and accumulate pipeline, adds the bias, saturates and registers the result
// the neurons of a sample are computed in turn through the single weight read port and mac
// reset clears control state and sets the size registers to 64 inputs and 16 outputs
// memory contents are not cleared by reset and there is no clearing pass

module dense_layer_forward_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire dlf_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output dlf_pkg::out_item_t             out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [dlf_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [dlf_pkg::DATA_W-1:0] wdata;
  logic                       w_we, w_re, a_we, a_re, b_we, b_re;
  logic [dlf_pkg::W_AW-1:0]   w_waddr, w_raddr;
  logic [dlf_pkg::IN_AW-1:0]  a_waddr, a_raddr;
  logic [dlf_pkg::OUT_AW-1:0] b_waddr, b_raddr;
  logic [dlf_pkg::DATA_W-1:0] w_rdata, a_rdata, b_rdata;
  dlf_pkg::mac_ctl_t          mac_ctl;
  dlf_pkg::mac_sts_t          mac_sts;
  dlf_pkg::mac_res_t          mac_res;

  // weight store
  dlf_ram #(
    .Width(dlf_pkg::DATA_W),
    .Depth(dlf_pkg::W_DEPTH)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(wdata),
    .re_i   (w_re),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  // activation buffer
  dlf_ram #(
    .Width(dlf_pkg::DATA_W),
    .Depth(dlf_pkg::MAX_INPUTS)
  ) u_act_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // bias store
  dlf_ram #(
    .Width(dlf_pkg::DATA_W),
    .Depth(dlf_pkg::MAX_OUTPUTS)
  ) u_bias_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(wdata),
    .re_i   (b_re),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  // multiply-accumulate datapath
  dlf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .w_rdata_i(w_rdata),
    .a_rdata_i(a_rdata),
    .b_rdata_i(b_rdata),
    .sts_o    (mac_sts),
    .res_o    (mac_res)
  );

  // sequencer and handshakes
  dlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wdata_o    (wdata),
    .w_we_o     (w_we),
    .w_waddr_o  (w_waddr),
    .w_re_o     (w_re),
    .w_raddr_o  (w_raddr),
    .a_we_o     (a_we),
    .a_waddr_o  (a_waddr),
    .a_re_o     (a_re),
    .a_raddr_o  (a_raddr),
    .b_we_o     (b_we),
    .b_waddr_o  (b_waddr),
    .b_re_o     (b_re),
    .b_raddr_o  (b_raddr),
    .mac_ctl_o  (mac_ctl),
    .mac_sts_i  (mac_sts),
    .mac_res_i  (mac_res)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // selector value the block must ignore
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 460;
  localparam int         PHASE_ITEMS  = 40;
  localparam int         DRAIN_CYCLES = 20;

  // expected layer outputs, computed from a private copy of the stores
  class layer_checker;
    logic [dlf_pkg::DATA_W-1:0] weights [dlf_pkg::MAX_OUTPUTS][dlf_pkg::MAX_INPUTS];
    logic [dlf_pkg::DATA_W-1:0] biases [dlf_pkg::MAX_OUTPUTS];
    logic [dlf_pkg::DATA_W-1:0] acts [dlf_pkg::MAX_INPUTS];
    bit                         wt_known [dlf_pkg::MAX_OUTPUTS][dlf_pkg::MAX_INPUTS];
    bit                         bias_known [dlf_pkg::MAX_OUTPUTS];
    int                         act_count;
    logic [dlf_pkg::CFG_W-1:0]  inputs_reg;
    logic [dlf_pkg::NOUT_W-1:0] outputs_reg;
    dlf_pkg::out_item_t         expected_outputs [$];
    int                         errors;

    function new();
      inputs_reg  = dlf_pkg::CFG_W'(dlf_pkg::MAX_INPUTS);
      outputs_reg = dlf_pkg::NOUT_W'(dlf_pkg::MAX_OUTPUTS);
      act_count   = 0;
      errors      = 0;
    endfunction

    function void write_reg(dlf_pkg::cfg_reg_e idx, logic [dlf_pkg::CFG_W-1:0] data);
      if (idx == dlf_pkg::REG_INPUTS) begin
        inputs_reg = data;
      end else begin
        outputs_reg = data[dlf_pkg::NOUT_W-1:0];
      end
    endfunction

    // zero acts as one, anything above the maximum as the maximum
    function int inputs_eff();
      if (inputs_reg == 0) return 1;
      return (inputs_reg > dlf_pkg::MAX_INPUTS) ? dlf_pkg::MAX_INPUTS : int'(inputs_reg);
    endfunction

    function int outputs_eff();
      if (outputs_reg == 0) return 1;
      return (outputs_reg > dlf_pkg::MAX_OUTPUTS) ? dlf_pkg::MAX_OUTPUTS : int'(outputs_reg);
    endfunction

    // elements summed if the next activation carries last
    function int used_on_last();
      int n;
      int c;
      n = inputs_eff();
      c = act_count;
      if (c < n) c++;
      return (c < n) ? c : n;
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // y = W x + b over the received elements, floor shift and saturate
    function void forward_layer();
      int                                   used;
      int                                   nout;
      int                                   n;
      int                                   k;
      logic signed [dlf_pkg::PROD_W-1:0]    prod;
      logic signed [dlf_pkg::ACC_WIDTH-1:0] acc;
      logic signed [dlf_pkg::ACC_WIDTH-1:0] shifted;
      dlf_pkg::out_item_t                   res;
      nout = outputs_eff();
      used = (act_count < inputs_eff()) ? act_count : inputs_eff();
      for (n = 0; n < nout; n++) begin
        acc = '0;
        for (k = 0; k < used; k++) begin
          prod = $signed(weights[n][k]) * $signed(acts[k]);
          acc  = acc + dlf_pkg::ACC_WIDTH'(prod);
        end
        acc     = acc + (dlf_pkg::ACC_WIDTH'($signed(biases[n])) <<< 8);
        shifted = acc >>> 8;
        res.neuron    = 4'(n);
        res.saturated = 1'b0;
        if (shifted > 32767) begin
          res.result    = 16'sh7fff;
          res.saturated = 1'b1;
        end else if (shifted < -32768) begin
          res.result    = 16'sh8000;
          res.saturated = 1'b1;
        end else begin
          res.result = shifted[dlf_pkg::DATA_W-1:0];
        end
        res.end_of_run = (n == nout - 1);
        expected_outputs = {expected_outputs, res};
      end
    endfunction

    // update the stores for one accepted input transaction
    function void take_item(dlf_pkg::in_item_t it);
      case (it.func)
        dlf_pkg::FUNC_WEIGHT: begin
          weights[it.row][it.col]  = it.value;
          wt_known[it.row][it.col] = 1'b1;
        end
        dlf_pkg::FUNC_BIAS: begin
          biases[it.row]     = it.value;
          bias_known[it.row] = 1'b1;
        end
        dlf_pkg::FUNC_ACT: begin
          if (act_count < inputs_eff() && act_count < dlf_pkg::MAX_INPUTS) begin
            acts[act_count] = it.value;
            act_count++;
          end
          if (it.last) begin
            forward_layer();
            act_count = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(dlf_pkg::out_item_t got);
      dlf_pkg::out_item_t want;
      if (expected_outputs.size() == 0) begin
        $error("output transaction with nothing expected: neuron %0d result %0d",
               got.neuron, got.result);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.neuron !== want.neuron) begin
        $error("neuron: expected %0d, got %0d", want.neuron, got.neuron);
        errors++;
      end
      if (got.result !== want.result) begin
        $error("result: expected %0d, got %0d", want.result, got.result);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
        errors++;
      end
      if (got.end_of_run !== want.end_of_run) begin
        $error("end_of_run: expected %0d, got %0d", want.end_of_run, got.end_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  dlf_pkg::in_item_t         in_data;
  logic                      out_valid;
  logic                      out_stall;
  dlf_pkg::out_item_t        out_data;
  logic                      cfg_we;
  logic [0:0]                cfg_idx;
  logic [dlf_pkg::CFG_W-1:0] cfg_wdata;

  layer_checker book;
  bit           no_gaps;
  bit           loading_params;
  int           item_count;

  dense_layer_forward_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  // mostly small q8.8 values, with extremes and full-range noise
  function automatic logic [dlf_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:             return 16'h7fff;
      1:             return 16'h8000;
      2, 3, 4, 5, 6: return 16'($urandom_range(0, 1023) - 512);
      7, 8:          return 16'($urandom_range(0, 16383) - 8192);
      default:       return 16'($urandom);
    endcase
  endfunction

  // one input transaction; called and returns at a falling edge, valid left high
  task automatic send(dlf_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    book.take_item(it);
    if (!loading_params && it.func != FUNC_UNUSED) item_count++;
    @(negedge clk);
  endtask

  task automatic send_weight(logic [3:0] row, logic [5:0] col,
                             logic [dlf_pkg::DATA_W-1:0] v, logic last);
    dlf_pkg::in_item_t it;
    it = '{func: dlf_pkg::FUNC_WEIGHT, row: row, col: col, value: v, last: last};
    send(it);
  endtask

  task automatic send_bias(logic [3:0] row, logic [dlf_pkg::DATA_W-1:0] v, logic last);
    dlf_pkg::in_item_t it;
    it = '{func: dlf_pkg::FUNC_BIAS, row: row, col: 6'($urandom_range(0, 63)), value: v,
           last: last};
    send(it);
  endtask

  task automatic send_noise(logic last);
    dlf_pkg::in_item_t it;
    it = '{func: FUNC_UNUSED, row: 4'($urandom_range(0, 15)), col: 6'($urandom_range(0, 63)),
           value: 16'($urandom), last: last};
    send(it);
  endtask

  // activation; before a last, load every weight and bias the sample will read
  task automatic send_act(logic [dlf_pkg::DATA_W-1:0] v, logic last);
    dlf_pkg::in_item_t it;
    int                rows;
    int                cols;
    int                r;
    int                c;
    if (last) begin
      rows = book.outputs_eff();
      cols = book.used_on_last();
      loading_params = 1'b1;
      for (r = 0; r < rows; r++) begin
        if (!book.bias_known[r]) send_bias(4'(r), pick_value(), 1'($urandom));
        for (c = 0; c < cols; c++) begin
          if (!book.wt_known[r][c]) send_weight(4'(r), 6'(c), pick_value(), 1'($urandom));
        end
      end
      loading_params = 1'b0;
    end
    it = '{func: dlf_pkg::FUNC_ACT, row: 4'($urandom_range(0, 15)),
           col: 6'($urandom_range(0, 63)), value: v, last: last};
    send(it);
  endtask

  // register write while the block is idle
  task automatic set_reg(dlf_pkg::cfg_reg_e idx, logic [dlf_pkg::CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(posedge clk);
    book.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drop valid, wait for every expected output, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // receiver: random stall before each output transaction
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_output(out_data);
  end

  // stimulus
  initial begin
    int          start;
    int          phase;
    int          len;
    int          n;
    int          i;
    int unsigned in_sizes [5];
    int unsigned out_sizes [5];
    in_sizes  = '{1, 64, 0, 127, 2};
    out_sizes = '{1, 16, 0, 31, 17};
    book           = new();
    no_gaps        = 1'b0;
    loading_params = 1'b0;
    item_count     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = dlf_pkg::REG_INPUTS;
    cfg_wdata      = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // extremes of weight, bias and activation, last on writes ignored
    set_reg(dlf_pkg::REG_INPUTS, 3);
    set_reg(dlf_pkg::REG_OUTPUTS, 2);
    send_weight(0, 0, 16'h7fff, 1'b1);
    send_weight(1, 0, 16'h8000, 1'b0);
    send_bias(0, 16'h7fff, 1'b1);
    send_bias(1, 16'h8000, 1'b0);
    send_noise(1'b1);
    send_act(16'h7fff, 1'b0);
    send_act(16'h8000, 1'b0);
    send_act(16'h0100, 1'b1);
    // short sample, one element
    send_act(16'h7fff, 1'b1);
    // extra elements past the input size are dropped
    for (i = 0; i < 5; i++) send_act(pick_value(), i == 4);
    send_act(16'h0000, 1'b1);
    settle();
    // zero sizes act as one
    set_reg(dlf_pkg::REG_INPUTS, 0);
    set_reg(dlf_pkg::REG_OUTPUTS, 0);
    send_act(16'hffff, 1'b1);
    settle();
    // input size shrinks with a sample half received
    set_reg(dlf_pkg::REG_INPUTS, 4);
    for (i = 0; i < 3; i++) send_act(pick_value(), 1'b0);
    settle();
    set_reg(dlf_pkg::REG_INPUTS, 2);
    send_act(pick_value(), 1'b1);

    // random phases, each with its own sizes
    start = item_count;
    phase = 0;
    while (item_count - start < RANDOM_ITEMS) begin
      settle();
      if (phase < 5) begin
        set_reg(dlf_pkg::REG_INPUTS, dlf_pkg::CFG_W'(in_sizes[phase]));
        set_reg(dlf_pkg::REG_OUTPUTS, dlf_pkg::CFG_W'(out_sizes[phase]));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6:
            set_reg(dlf_pkg::REG_INPUTS, dlf_pkg::CFG_W'($urandom_range(1, 12)));
          7:
            set_reg(dlf_pkg::REG_INPUTS, dlf_pkg::CFG_W'(dlf_pkg::MAX_INPUTS));
          8:
            set_reg(dlf_pkg::REG_INPUTS, dlf_pkg::CFG_W'($urandom_range(65, 127)));
          default:
            set_reg(dlf_pkg::REG_INPUTS, dlf_pkg::CFG_W'($urandom_range(13, 63)));
        endcase
        set_reg(dlf_pkg::REG_OUTPUTS, dlf_pkg::CFG_W'($urandom_range(0, 31)));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = item_count;
      while (item_count - n < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          14, 15: send_weight(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                              pick_value(), 1'($urandom));
          16: send_bias(4'($urandom_range(0, 15)), pick_value(), 1'($urandom));
          17: send_noise(1'($urandom));
          18: send_act(pick_value(), 1'b0);
          19: send_act(pick_value(), 1'b1);
          default: begin
            // well-formed sample of random content and length
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: len = book.inputs_eff();
              7:                len = book.inputs_eff() + int'($urandom_range(1, 4));
              8:                len = 1;
              default:          len = int'($urandom_range(1, book.inputs_eff()));
            endcase
            for (i = 0; i < len; i++) begin
              if ($urandom_range(0, 19) == 0) begin
                send_weight(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                            pick_value(), 1'($urandom));
              end
              send_act(pick_value(), i == len - 1);
            end
          end
        endcase
      end
      // sometimes leave a sample open across the size change
      if ($urandom_range(0, 2) == 0) begin
        len = int'($urandom_range(1, 3));
        for (i = 0; i < len; i++) send_act(pick_value(), 1'b0);
      end
      phase++;
    end
    no_gaps = 1'b0;
    settle();

    if (book.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
